// ===== rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg - shared types and constants of the rgb/hsl colour converter
// pipeline depth, direction codes, fixed-point lookup table, channel hue offsets
// ----------------------------------------------------------------------------
package rhc_pkg;

    localparam int NSTAGES = 6;

    // direction select on func
    localparam logic FUNC_TO_HSL = 1'b0;
    localparam logic FUNC_TO_RGB = 1'b1;

    typedef logic [NSTAGES-1:0] t_stage_vec;
    typedef logic [16:0]        t_q16;
    typedef t_q16               t_q16_tab [256];
    typedef logic [7:0]         t_offs_tab [3];

    // hue offsets 0, 8 and 4 on the twelve-sector circle, in units of 1/20
    localparam t_offs_tab HUE_OFFS = '{8'd0, 8'd160, 8'd80};

    // round(x * 65536 / 240), ties away from zero
    function automatic t_q16_tab make_q16_tab();
        t_q16_tab t;
        for (int i = 0; i < 256; i++) begin
            t[i] = 17'((2 * i * 65536 + 240) / 480);
        end
        return t;
    endfunction

    localparam t_q16_tab Q16_TAB = make_q16_tab();

endpackage

// ===== rtl/rhc_div.sv =====
// ----------------------------------------------------------------------------
// rhc_div - pipelined restoring divider
// 8-bit quotient of a 17-bit dividend, two quotient bits per stage
// ----------------------------------------------------------------------------
module rhc_div (
    input  logic        i_clk,
    input  logic [3:0]  i_en,
    input  logic [16:0] i_num,
    input  logic [8:0]  i_den,
    output logic [7:0]  o_quo
);
    import rhc_pkg::*;

    logic [16:0] r_rem [4];
    logic [8:0]  r_den [4];
    logic [7:0]  r_quo [4];
    logic [16:0] n_rem [4];
    logic [7:0]  n_quo [4];

    always_comb begin
        logic [16:0] rem;
        logic [16:0] sh;
        logic [8:0]  den;
        logic [7:0]  quo;
        for (int j = 0; j < 4; j++) begin
            rem = (j == 0) ? i_num : r_rem[(j == 0) ? 0 : j - 1];
            den = (j == 0) ? i_den : r_den[(j == 0) ? 0 : j - 1];
            quo = (j == 0) ? 8'd0  : r_quo[(j == 0) ? 0 : j - 1];
            for (int b = 0; b < 2; b++) begin
                sh = 17'(den) << (7 - 2 * j - b);
                if (rem >= sh) begin
                    rem = rem - sh;
                    quo[3'(7 - 2 * j - b)] = 1'b1;
                end
            end
            n_rem[j] = rem;
            n_quo[j] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++) begin
            if (i_en[j]) begin
                r_rem[j] <= n_rem[j];
                r_quo[j] <= n_quo[j];
                r_den[j] <= (j == 0) ? i_den : r_den[(j == 0) ? 0 : j - 1];
            end
        end
    end

    assign o_quo = r_quo[3];

endmodule

// ===== rtl/rhc_rgb2hsl.sv =====
// ----------------------------------------------------------------------------
// rhc_rgb2hsl - rgb to hsl datapath
// max/min front end, constant scaling, two shared-shape dividers
// ----------------------------------------------------------------------------
module rhc_rgb2hsl (
    input  logic               i_clk,
    input  rhc_pkg::t_stage_vec i_en,
    input  logic [7:0]         i_red,
    input  logic [7:0]         i_green,
    input  logic [7:0]         i_blue,
    output logic [7:0]         o_hue,
    output logic [7:0]         o_sat,
    output logic [7:0]         o_light,
    output logic               o_grey
);
    import rhc_pkg::*;

    // stage 1
    logic [7:0]  r1_d, n1_d;
    logic [8:0]  r1_sum, n1_sum;
    logic [7:0]  r1_den, n1_den;
    logic [10:0] r1_num, n1_num;

    always_comb begin
        logic [7:0] mx;
        logic [7:0] mn;
        mx = i_red;
        mn = i_red;
        if (i_green > mx) mx = i_green;
        if (i_blue > mx)  mx = i_blue;
        if (i_green < mn) mn = i_green;
        if (i_blue < mn)  mn = i_blue;
        n1_d   = mx - mn;
        n1_sum = 9'(mx) + 9'(mn);
        n1_den = (n1_sum <= 9'd255) ? n1_sum[7:0] : 8'(9'd510 - n1_sum);
        if (mx == i_red) begin
            n1_num = (i_green >= i_blue) ? 11'(i_green - i_blue)
                                         : 11'(n1_d) * 11'd6 - 11'(i_blue - i_green);
        end else if (mx == i_green) begin
            n1_num = 11'(n1_d) * 11'd2 + 11'(i_blue) - 11'(i_red);
        end else begin
            n1_num = 11'(n1_d) * 11'd4 + 11'(i_red) - 11'(i_green);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r1_d   <= n1_d;
            r1_sum <= n1_sum;
            r1_den <= n1_den;
            r1_num <= n1_num;
        end
    end

    // stage 2: divider operands and lightness by reciprocal of 34
    logic [16:0] r2_hnum, r2_snum;
    logic [8:0]  r2_hden, r2_sden;
    logic [7:0]  r_light [5];
    logic        r_grey  [5];
    logic [26:0] lprod;

    assign lprod = (27'(r1_sum) * 27'd16 + 27'd17) * 27'd7711;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r2_hnum    <= 17'(r1_num) * 17'd80 + 17'(r1_d);
            r2_hden    <= {r1_d, 1'b0};
            r2_snum    <= 17'(r1_d) * 17'd480 + 17'(r1_den);
            r2_sden    <= {r1_den, 1'b0};
            r_light[0] <= lprod[25:18];
            r_grey[0]  <= (r1_d == 8'd0);
        end
        for (int j = 1; j < 5; j++) begin
            if (i_en[j + 1]) begin
                r_light[j] <= r_light[j - 1];
                r_grey[j]  <= r_grey[j - 1];
            end
        end
    end

    rhc_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (i_en[5:2]),
        .i_num (r2_hnum),
        .i_den (r2_hden),
        .o_quo (o_hue)
    );

    rhc_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (i_en[5:2]),
        .i_num (r2_snum),
        .i_den (r2_sden),
        .o_quo (o_sat)
    );

    assign o_light = r_light[4];
    assign o_grey  = r_grey[4];

endmodule

// ===== rtl/rhc_hsl2rgb.sv =====
// ----------------------------------------------------------------------------
// rhc_hsl2rgb - hsl to rgb datapath
// per-channel clamp formula in q16 fixed point, six register stages
// ----------------------------------------------------------------------------
module rhc_hsl2rgb (
    input  logic               i_clk,
    input  rhc_pkg::t_stage_vec i_en,
    input  logic [7:0]         i_hue,
    input  logic [7:0]         i_sat,
    input  logic [7:0]         i_light,
    output logic [7:0]         o_red,
    output logic [7:0]         o_green,
    output logic [7:0]         o_blue
);
    import rhc_pkg::*;

    // stage 1: table lookups and clamp term
    t_q16              r1_l16, r1_s16;
    logic signed [5:0] r1_a [3];
    logic signed [5:0] n1_a [3];

    always_comb begin
        logic [8:0]        ksum;
        logic [7:0]        kmod;
        logic signed [9:0] t1;
        logic signed [9:0] t2;
        logic signed [9:0] am;
        for (int c = 0; c < 3; c++) begin
            ksum = 9'(i_hue) + 9'(HUE_OFFS[c]);
            kmod = (ksum >= 9'd240) ? 8'(ksum - 9'd240) : ksum[7:0];
            t1   = signed'({2'b00, kmod}) - 10'sd60;
            t2   = 10'sd180 - signed'({2'b00, kmod});
            am   = (t1 < t2) ? t1 : t2;
            if (am > 10'sd20)  am = 10'sd20;
            if (am < -10'sd20) am = -10'sd20;
            n1_a[c] = am[5:0];
        end
    end

    // stage 2: s * min(l, 1 - l)
    logic signed [17:0] l16s, l16inv, m16;
    logic signed [35:0] r2_p1;
    logic [21:0]        r2_l20;
    logic signed [5:0]  r2_a [3];

    assign l16s   = signed'({1'b0, r1_l16});
    assign l16inv = 18'sd65536 - l16s;
    assign m16    = (l16s < l16inv) ? l16s : l16inv;

    // stages 3 to 6
    logic signed [41:0] r3_p [3];
    logic [21:0]        r3_l20;
    logic signed [42:0] r4_v [3];
    logic [11:0]        r5_t [3];
    logic               r5_pos [3];
    logic [7:0]         r6_ch [3];
    logic [7:0]         n6_ch [3];

    always_comb begin
        logic [27:0] prod;
        for (int c = 0; c < 3; c++) begin
            prod = 28'(r5_t[c]) * 28'd52429;
            if (!r5_pos[c]) begin
                n6_ch[c] = 8'd0;
            end else if (prod[27:18] > 10'd255) begin
                n6_ch[c] = 8'd255;
            end else begin
                n6_ch[c] = prod[25:18];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        logic signed [52:0] w;
        if (i_en[0]) begin
            r1_l16 <= Q16_TAB[i_light];
            r1_s16 <= Q16_TAB[i_sat];
            r1_a   <= n1_a;
        end
        if (i_en[1]) begin
            r2_p1  <= signed'({1'b0, r1_s16}) * m16;
            r2_l20 <= 22'(r1_l16) * 22'd20;
            r2_a   <= r1_a;
        end
        if (i_en[2]) begin
            for (int c = 0; c < 3; c++) r3_p[c] <= r2_p1 * r2_a[c];
            r3_l20 <= r2_l20;
        end
        if (i_en[3]) begin
            for (int c = 0; c < 3; c++) begin
                r4_v[c] <= signed'({1'b0, r3_l20, 16'd0}) - r3_p[c];
            end
        end
        if (i_en[4]) begin
            for (int c = 0; c < 3; c++) begin
                // 510 * v + 20 * 2^32, then divide by 2^35
                w = (53'(r4_v[c]) <<< 9) - (53'(r4_v[c]) <<< 1)
                    + 53'sd85899345920;
                r5_t[c]   <= w[46:35];
                r5_pos[c] <= (r4_v[c] > 43'sd0);
            end
        end
        if (i_en[5]) begin
            r6_ch <= n6_ch;
        end
    end

    assign o_red   = r6_ch[0];
    assign o_green = r6_ch[1];
    assign o_blue  = r6_ch[2];

endmodule

// ===== rtl/rgb_hsl_color_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_hsl_color_converter - pixel converter between 8-bit rgb and hsl (0..240)
// six-stage pipeline, both directions computed side by side, func selects
// ----------------------------------------------------------------------------
//
//  channel   handshake            payload
//  -------   ------------------   -----------------------------------------
//  input     i_valid / o_ready    i_func, i_red_in..i_blue_in, i_hue_in..
//  output    o_valid / i_ready    o_hue_out..o_light_out, o_red_out..
//
// one transaction per clock sustained while the output is not stalled;
// six register stages, the depth being set by the two front stages and
// the four divider stages of rgb to hsl
// each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so a stall at the output fills bubbles first
// reset clears the valid bits only; datapath registers are left as they are
//
module rgb_hsl_color_converter (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_func,
    input  logic [7:0] i_red_in,
    input  logic [7:0] i_green_in,
    input  logic [7:0] i_blue_in,
    input  logic [7:0] i_hue_in,
    input  logic [7:0] i_sat_in,
    input  logic [7:0] i_light_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_hue_out,
    output logic [7:0] o_sat_out,
    output logic [7:0] o_light_out,
    output logic [7:0] o_red_out,
    output logic [7:0] o_green_out,
    output logic [7:0] o_blue_out
);
    import rhc_pkg::*;

    t_stage_vec r_valid, n_valid, en;
    logic       r_func [NSTAGES];

    // stage enables, last stage first
    always_comb begin
        en[NSTAGES-1] = !r_valid[NSTAGES-1] || i_ready;
        for (int k = NSTAGES - 2; k >= 0; k--) begin
            en[k] = !r_valid[k] || en[k + 1];
        end
        for (int k = 0; k < NSTAGES; k++) begin
            if (en[k]) begin
                n_valid[k] = (k == 0) ? i_valid : r_valid[(k == 0) ? 0 : k - 1];
            end else begin
                n_valid[k] = r_valid[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // direction select travels alongside the data
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NSTAGES; k++) begin
            if (en[k]) begin
                r_func[k] <= (k == 0) ? i_func : r_func[(k == 0) ? 0 : k - 1];
            end
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_valid[NSTAGES-1];

    logic [7:0] hue, sat, light, red, green, blue;
    logic       grey;

    rhc_rgb2hsl u_rgb2hsl (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .o_hue   (hue),
        .o_sat   (sat),
        .o_light (light),
        .o_grey  (grey)
    );

    rhc_hsl2rgb u_hsl2rgb (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_hue   (i_hue_in),
        .i_sat   (i_sat_in),
        .i_light (i_light_in),
        .o_red   (red),
        .o_green (green),
        .o_blue  (blue)
    );

    // unused direction reads as zero; grey pixels have no hue or saturation
    logic func_out;
    assign func_out    = r_func[NSTAGES-1];
    assign o_hue_out   = (func_out || grey) ? 8'd0 : hue;
    assign o_sat_out   = (func_out || grey) ? 8'd0 : sat;
    assign o_light_out = func_out ? 8'd0 : light;
    assign o_red_out   = func_out ? red   : 8'd0;
    assign o_green_out = func_out ? green : 8'd0;
    assign o_blue_out  = func_out ? blue  : 8'd0;

    // a stalled result is never dropped from the last stage
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid)
        else $error("result lost while stalled");

    // input is refused only when the whole pipe is full
    a_full_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_valid == '1))
        else $error("input refused with a bubble in the pipe");

    // an accepted transaction always lands in the first stage
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_valid[0])
        else $error("accepted transaction missing from first stage");

endmodule

// ===== tb/sv/rgb_hsl_color_converter_chk.sv =====
// ----------------------------------------------------------------------------
// rgb_hsl_color_converter_chk - pixel conversion checker
// watches both channels, predicts each converted pixel and compares in order
// ----------------------------------------------------------------------------
module rgb_hsl_color_converter_chk (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  logic        i_func,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [7:0]  i_hue_in,
    input  logic [7:0]  i_sat_in,
    input  logic [7:0]  i_light_in,
    input  logic        o_valid,
    input  logic        i_ready,
    input  logic [7:0]  o_hue_out,
    input  logic [7:0]  o_sat_out,
    input  logic [7:0]  o_light_out,
    input  logic [7:0]  o_red_out,
    input  logic [7:0]  o_green_out,
    input  logic [7:0]  o_blue_out,
    output int          o_errors,
    output int          o_pending
);
    import rhc_pkg::*;

    typedef struct packed {
        logic [7:0] hue, sat, light, red, green, blue;
    } t_pixel;

    t_pixel pixel_q[$];
    int     errors = 0;

    assign o_errors  = errors;
    assign o_pending = pixel_q.size();

    function automatic longint round_div(longint num, longint den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic logic [7:0] hsl_chan(longint offs, longint h, longint l16, longint s16);
        longint m16, k, a, v, q;
        m16 = (l16 < 65536 - l16) ? l16 : 65536 - l16;
        k = (20 * offs + h) % 240;
        a = k - 60;
        if (180 - k < a) a = 180 - k;
        if (a > 20) a = 20;
        if (a < -20) a = -20;
        v = l16 * 65536 * 20 - s16 * m16 * a;
        if (v <= 0) return 8'd0;
        q = round_div(v * 255, 64'd20 * 64'd4294967296);
        return (q > 255) ? 8'd255 : 8'(q);
    endfunction

    function automatic t_pixel convert_pixel(logic fn, logic [7:0] r8, logic [7:0] g8,
                                             logic [7:0] b8, logic [7:0] h8,
                                             logic [7:0] s8, logic [7:0] l8);
        t_pixel p;
        longint r, g, b, mx, mn, d, sm, den, num, st, l16, s16;
        p = '0;
        if (fn == FUNC_TO_HSL) begin
            r = longint'(r8); g = longint'(g8); b = longint'(b8);
            mx = r; mn = r;
            if (g > mx) mx = g;
            if (b > mx) mx = b;
            if (g < mn) mn = g;
            if (b < mn) mn = b;
            d = mx - mn;
            sm = mx + mn;
            p.light = 8'(round_div(sm * 240, 510));
            if (d != 0) begin
                den = (sm <= 255) ? sm : 510 - sm;
                st = round_div(d * 240, den);
                if (mx == r) num = (g >= b) ? g - b : 6 * d - (b - g);
                else if (mx == g) num = 2 * d + b - r;
                else num = 4 * d + r - g;
                p.hue = 8'(round_div(40 * num, d));
                p.sat = (st > 255) ? 8'd255 : 8'(st);
            end
        end else begin
            l16 = round_div(longint'(l8) * 65536, 240);
            s16 = round_div(longint'(s8) * 65536, 240);
            p.red   = hsl_chan(0, longint'(h8), l16, s16);
            p.green = hsl_chan(8, longint'(h8), l16, s16);
            p.blue  = hsl_chan(4, longint'(h8), l16, s16);
        end
        return p;
    endfunction

    task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
        errors++;
        $display("mismatch on %s: got %0d, expected %0d", field, got, want);
    endtask

    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                pixel_q.push_back(convert_pixel(i_func, i_red_in, i_green_in, i_blue_in,
                                                i_hue_in, i_sat_in, i_light_in));
            if (o_valid && i_ready) begin
                if (pixel_q.size() == 0) begin
                    errors++;
                    $display("unexpected result transaction");
                end else begin
                    want = pixel_q.pop_front();
                    if (o_hue_out !== want.hue) report_mismatch("hue", o_hue_out, want.hue);
                    if (o_sat_out !== want.sat) report_mismatch("sat", o_sat_out, want.sat);
                    if (o_light_out !== want.light)
                        report_mismatch("light", o_light_out, want.light);
                    if (o_red_out !== want.red) report_mismatch("red", o_red_out, want.red);
                    if (o_green_out !== want.green)
                        report_mismatch("green", o_green_out, want.green);
                    if (o_blue_out !== want.blue)
                        report_mismatch("blue", o_blue_out, want.blue);
                end
            end
        end
    end

endmodule

// ===== tb/sv/rgb_hsl_color_converter_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_hsl_color_converter_tb - testbench of the rgb/hsl colour converter
// directed corner pixels then random pixels in both directions, random
// gaps on both sides, a long output stall and a drain pause; a separate
// checker predicts every result and counts mismatches
// ----------------------------------------------------------------------------
module rgb_hsl_color_converter_tb;
    import rhc_pkg::*;

    localparam int N_RANDOM = 680;
    localparam int WDOG_MAX = 2000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic       i_func = 1'b0;
    logic [7:0] i_red_in = '0, i_green_in = '0, i_blue_in = '0;
    logic [7:0] i_hue_in = '0, i_sat_in = '0, i_light_in = '0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_hue_out, o_sat_out, o_light_out, o_red_out, o_green_out, o_blue_out;
    int         errors, pending;
    bit         hold_rx = 1'b0;
    int         idle_cycles = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    rgb_hsl_color_converter i_dut (.*);

    rgb_hsl_color_converter_chk i_chk (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_func, .i_red_in, .i_green_in,
        .i_blue_in, .i_hue_in, .i_sat_in, .i_light_in, .o_valid, .i_ready,
        .o_hue_out, .o_sat_out, .o_light_out, .o_red_out, .o_green_out,
        .o_blue_out, .o_errors(errors), .o_pending(pending)
    );

    // offer one pixel after a random gap, hold it until the transaction
    task automatic send_pixel(logic fn, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] h, logic [7:0] s, logic [7:0] l);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
        if ($urandom_range(0, 2) == 0) gap = 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_func <= fn;
        i_red_in <= r; i_green_in <= g; i_blue_in <= b;
        i_hue_in <= h; i_sat_in <= s; i_light_in <= l;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // drop valid after the last transaction of a burst
    task automatic end_burst();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic send_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        send_pixel(FUNC_TO_HSL, r, g, b, 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic send_hsl(logic [7:0] h, logic [7:0] s, logic [7:0] l);
        send_pixel(FUNC_TO_RGB, 8'($urandom), 8'($urandom), 8'($urandom), h, s, l);
    endtask

    // receiver: random stalls, plus one long hold-off when asked
    initial begin
        int wait_cycles;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_ready <= 1'b0;
                repeat (60) @(negedge i_clk);
                hold_rx = 1'b0;
            end
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
            if ($urandom_range(0, 3) == 0) wait_cycles = 0;
            if (wait_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (wait_cycles - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!(o_valid && i_ready) && !hold_rx) @(posedge i_clk);
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        int sel;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: greys, primaries, ties, hue close to 240, extremes
        send_rgb(8'd0, 8'd0, 8'd0);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd128, 8'd128, 8'd128);
        send_rgb(8'd255, 8'd0, 8'd0);
        send_rgb(8'd0, 8'd255, 8'd0);
        send_rgb(8'd0, 8'd0, 8'd255);
        send_rgb(8'd255, 8'd255, 8'd0);
        send_rgb(8'd0, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd0, 8'd255);
        send_rgb(8'd255, 8'd0, 8'd1);
        send_rgb(8'd255, 8'd254, 8'd255);
        send_rgb(8'd1, 8'd0, 8'd0);
        send_rgb(8'd255, 8'd254, 8'd254);
        send_hsl(8'd0, 8'd0, 8'd0);
        send_hsl(8'd0, 8'd0, 8'd240);
        send_hsl(8'd100, 8'd0, 8'd120);
        send_hsl(8'd0, 8'd240, 8'd120);
        send_hsl(8'd80, 8'd240, 8'd120);
        send_hsl(8'd160, 8'd240, 8'd120);
        send_hsl(8'd240, 8'd240, 8'd240);
        send_hsl(8'd255, 8'd255, 8'd255);
        send_hsl(8'd30, 8'd250, 8'd60);
        send_hsl(8'd200, 8'd255, 8'd250);
        end_burst();

        // drain pause: wait for every expected result before going on
        while (pending != 0) @(negedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 200) hold_rx = 1'b1;
            sel = $urandom_range(0, 9);
            if (sel < 4) send_rgb(8'($urandom), 8'($urandom), 8'($urandom));
            else if (sel < 8) send_hsl(8'($urandom_range(0, 240)), 8'($urandom_range(0, 240)),
                                       8'($urandom_range(0, 240)));
            else if (sel == 8) send_hsl(8'($urandom), 8'($urandom), 8'($urandom));
            else send_rgb(8'($urandom_range(0, 3) * 85), 8'($urandom_range(250, 255)),
                          8'($urandom_range(0, 5)));
        end
        end_burst();

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
